// ===== hdl/plcl_pkg.sv =====
// Package for the piecewise-linear curve lookup core.
// Holds shared constants, status codes, state encoding and the divider control struct.
// No dependencies.
package plcl_pkg;
	localparam int MAX_POINTS_DEF = 32;
	localparam int KEY_BITS_DEF   = 16;
	localparam int PCT_BITS       = 32;
	localparam int RATE_BITS      = 40;
	localparam int STAT_BITS      = 2;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	localparam logic [STAT_BITS-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_BITS-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_BITS-1:0] STAT_FULL  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_CHK,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_WRITE,
		ST_RD_PAIR,
		ST_PAIR_WAIT,
		ST_MUL,
		ST_DIV,
		ST_ADD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
	} div_ctl_t;
endpackage

// ===== hdl/plcl_div.sv =====
// Serial restoring divider for the interpolation quotient.
// One quotient bit per cycle. Depends on plcl_pkg.
module plcl_div #(
	parameter int NUM_BITS = 56,
	parameter int DEN_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] num,
	input  logic [DEN_BITS-1:0] den,
	output plcl_pkg::div_ctl_t  ctl,
	output logic [NUM_BITS-1:0] quo
);
	localparam int CNT_BITS = $clog2(NUM_BITS + 1);

	logic [NUM_BITS-1:0] quo_q;
	logic [DEN_BITS:0]   rem_q;
	logic [DEN_BITS-1:0] den_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic [DEN_BITS:0]   trial;
	logic [DEN_BITS:0]   diff;

	assign trial = {rem_q[DEN_BITS-1:0], quo_q[NUM_BITS-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_BITS'(NUM_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_BITS'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[DEN_BITS]) begin
				rem_q <= diff;
				quo_q <= {quo_q[NUM_BITS-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NUM_BITS-2:0], 1'b0};
			end
		end
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q;
	assign quo       = quo_q;
endmodule

// ===== hdl/piecewise_linear_curve_lookup_core.sv =====
// Piecewise-linear curve lookup core, top level.
// Depends on plcl_pkg and plcl_div.
//
// Usage: one request channel (req_valid/req_stall with func, key_day, pct_value)
// and one result channel (rsp_valid/rsp_stall with rate_out, status).
// func 0 inserts or overwrites a point; the percent value is stored as a
// fraction with 24 fraction bits (value * 256 / 100, rounded to nearest).
// func 1 looks up the curve at key_day with flat extrapolation at both ends
// and linear interpolation between points, truncated toward zero.
// Each request gives exactly one result.
// Points live in two synchronous memories (keys, values) with registered
// read data. A request is handled alone: a linear scan (ST_SCAN, ST_SCAN_CHK
// per entry), then for an insert a shift-up pass (ST_SHIFT_RD, ST_SHIFT_WR
// per moved point), or for an interior lookup a pair read, one multiply and
// a serial division of RATE_BITS+KEY_BITS+1 quotient bits.
// The result is held in an output register while rsp_stall is high; a new
// request is taken in the same cycle the held result leaves. Reset empties
// the curve.
module piecewise_linear_curve_lookup_core #(
	parameter int MAX_POINTS = plcl_pkg::MAX_POINTS_DEF,
	parameter int KEY_BITS   = plcl_pkg::KEY_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    req_valid,
	output logic                                    req_stall,
	input  logic                                    func,
	input  logic [15:0]                             key_day,
	input  logic signed [plcl_pkg::PCT_BITS-1:0]    pct_value,
	output logic                                    rsp_valid,
	input  logic                                    rsp_stall,
	output logic signed [plcl_pkg::RATE_BITS-1:0]   rate_out,
	output logic [plcl_pkg::STAT_BITS-1:0]          status
);
	localparam int RB  = plcl_pkg::RATE_BITS;
	localparam int PB  = plcl_pkg::PCT_BITS;
	localparam int AB  = $clog2(MAX_POINTS);
	localparam int CB  = $clog2(MAX_POINTS + 1);
	localparam int NB  = RB + 1 + KEY_BITS;

	// divide by 25 through reciprocals: 2^37/25 for 32 bits, 2^16/25 for 11 bits
	localparam logic [32:0] RECIP_25       = 33'd5497558139;
	localparam logic [11:0] RECIP_25_SMALL = 12'd2622;

	plcl_pkg::state_t state_q, state_d;

	logic [KEY_BITS-1:0] key_mem [MAX_POINTS];
	logic [RB-1:0]       val_mem [MAX_POINTS];
	logic [KEY_BITS-1:0] key_rd_s1;
	logic [RB-1:0]       val_rd_s1;
	logic                mem_we;
	logic [AB-1:0]       mem_wa, mem_ra;
	logic [KEY_BITS-1:0] mem_wk;
	logic [RB-1:0]       mem_wv;

	logic [CB-1:0]       count_q;
	logic [CB-1:0]       idx_q;
	logic [CB-1:0]       pos_q;
	logic                new_q;
	logic                func_q;
	logic [KEY_BITS-1:0] key_q;
	logic [KEY_BITS-1:0] t1_q;
	logic [KEY_BITS-1:0] t2_q;
	logic [RB-1:0]       r1_q;
	logic                neg_q;
	logic [RB:0]         mag_q;
	logic [KEY_BITS-1:0] span_q;
	logic                rsp_valid_q;
	logic [RB-1:0]       rate_q;
	logic [plcl_pkg::STAT_BITS-1:0] status_q;

	logic                accept;
	logic                hit;
	logic                same;
	logic                scan_end;
	logic                full;
	logic [RB:0]         diff;
	logic                div_start;
	logic [NB-1:0]       div_num;
	logic [NB-1:0]       div_quo;
	plcl_pkg::div_ctl_t  div_ctl;

	logic [PB-1:0]       pct_mag;
	logic [64:0]         recip_prod;
	logic [PB-1:0]       mag_s1;
	logic                neg_s1;
	logic [27:0]         quo25_s1;
	logic [31:0]         rem25;
	logic [10:0]         x_s2;
	logic [27:0]         a_s2;
	logic                neg_s2;
	logic [21:0]         small_prod;
	logic [33:0]         conv_mag;
	logic [RB-1:0]       conv;

	assign req_stall = (state_q != plcl_pkg::ST_IDLE) || (rsp_valid_q && rsp_stall);
	assign accept    = req_valid && !req_stall;

	assign hit      = key_rd_s1 >= key_q;
	assign same     = key_rd_s1 == key_q;
	assign scan_end = idx_q == count_q;
	assign full     = count_q == CB'(MAX_POINTS);

	// percent to fraction: (|p|*256 + 50) / 100 = (|p|*64 + 12) / 25, sign applied last
	assign pct_mag    = pct_value[PB-1] ? PB'(-pct_value) : PB'(pct_value);
	assign recip_prod = 65'(pct_mag) * 65'(RECIP_25);
	assign rem25      = mag_s1 - 32'({quo25_s1, 4'd0}) - 32'({quo25_s1, 3'd0})
		- 32'(quo25_s1);
	assign small_prod = 22'(x_s2) * 22'(RECIP_25_SMALL);
	assign conv_mag   = {a_s2, 6'd0} + 34'(small_prod[21:16]);
	assign conv       = neg_s2 ? RB'(0) - RB'(conv_mag) : RB'(conv_mag);

	always_ff @(posedge clk) begin
		x_s2   <= {rem25[4:0], 6'd0} + 11'd12;
		a_s2   <= quo25_s1;
		neg_s2 <= neg_s1;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[mem_wa] <= mem_wk;
			val_mem[mem_wa] <= mem_wv;
		end
		key_rd_s1 <= key_mem[mem_ra];
		val_rd_s1 <= val_mem[mem_ra];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			plcl_pkg::ST_IDLE: begin
				if (accept) state_d = plcl_pkg::ST_SCAN;
			end
			plcl_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_d = (func_q == plcl_pkg::FUNC_INSERT && !full)
						? plcl_pkg::ST_WRITE : plcl_pkg::ST_DONE;
				end else begin
					state_d = plcl_pkg::ST_SCAN_CHK;
				end
			end
			plcl_pkg::ST_SCAN_CHK: begin
				if (hit) begin
					if (func_q == plcl_pkg::FUNC_INSERT) begin
						state_d = same ? plcl_pkg::ST_WRITE
							: full ? plcl_pkg::ST_DONE
							: plcl_pkg::ST_SHIFT_RD;
					end else begin
						state_d = (idx_q == '0 || same)
							? plcl_pkg::ST_DONE : plcl_pkg::ST_RD_PAIR;
					end
				end else begin
					state_d = plcl_pkg::ST_SCAN;
				end
			end
			plcl_pkg::ST_SHIFT_RD:  state_d = plcl_pkg::ST_SHIFT_WR;
			plcl_pkg::ST_SHIFT_WR: begin
				state_d = (idx_q == pos_q + CB'(1)) ? plcl_pkg::ST_WRITE
					: plcl_pkg::ST_SHIFT_RD;
			end
			plcl_pkg::ST_WRITE:     state_d = plcl_pkg::ST_DONE;
			plcl_pkg::ST_RD_PAIR:   state_d = plcl_pkg::ST_PAIR_WAIT;
			plcl_pkg::ST_PAIR_WAIT: state_d = plcl_pkg::ST_MUL;
			plcl_pkg::ST_MUL:       state_d = plcl_pkg::ST_DIV;
			plcl_pkg::ST_DIV: begin
				if (!div_ctl.start && !div_ctl.busy) state_d = plcl_pkg::ST_ADD;
			end
			plcl_pkg::ST_ADD:       state_d = plcl_pkg::ST_DONE;
			plcl_pkg::ST_DONE:      state_d = plcl_pkg::ST_IDLE;
			default:                state_d = plcl_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_wa    = idx_q[AB-1:0];
		mem_ra    = idx_q[AB-1:0];
		mem_wk    = key_rd_s1;
		mem_wv    = val_rd_s1;
		div_start = 1'b0;
		case (state_q)
			plcl_pkg::ST_SHIFT_RD: begin
				mem_ra = AB'(idx_q - CB'(1));
			end
			plcl_pkg::ST_SHIFT_WR: begin
				mem_we = 1'b1;
			end
			plcl_pkg::ST_WRITE: begin
				mem_we = 1'b1;
				mem_wa = pos_q[AB-1:0];
				mem_wk = key_q;
				mem_wv = conv;
			end
			plcl_pkg::ST_RD_PAIR: begin
				mem_ra = AB'(pos_q - CB'(1));
			end
			plcl_pkg::ST_MUL: begin
				div_start = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign div_num = NB'(mag_q) * NB'(key_q - t1_q);

	plcl_div #(
		.NUM_BITS(NB),
		.DEN_BITS(KEY_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (span_q),
		.ctl    (div_ctl),
		.quo    (div_quo)
	);

	assign diff = {rate_q[RB-1], rate_q} - {val_rd_s1[RB-1], val_rd_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= plcl_pkg::ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == plcl_pkg::ST_DONE) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (state_q == plcl_pkg::ST_WRITE && new_q) count_q <= count_q + CB'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			plcl_pkg::ST_IDLE: begin
				if (accept) begin
					func_q   <= func;
					key_q    <= KEY_BITS'(key_day);
					idx_q    <= '0;
					pos_q    <= '0;
					new_q    <= 1'b0;
					status_q <= plcl_pkg::STAT_OK;
					rate_q   <= '0;
					mag_s1   <= pct_mag;
					neg_s1   <= pct_value[PB-1];
					quo25_s1 <= recip_prod[64:37];
				end
			end
			plcl_pkg::ST_SCAN: begin
				if (scan_end) begin
					pos_q <= idx_q;
					if (func_q == plcl_pkg::FUNC_INSERT) begin
						if (full) status_q <= plcl_pkg::STAT_FULL;
						else new_q <= 1'b1;
					end else if (count_q == '0) begin
						status_q <= plcl_pkg::STAT_EMPTY;
					end
				end
			end
			plcl_pkg::ST_SCAN_CHK: begin
				if (hit) begin
					pos_q <= idx_q;
					if (func_q == plcl_pkg::FUNC_INSERT) begin
						if (!same) begin
							if (full) begin
								status_q <= plcl_pkg::STAT_FULL;
							end else begin
								new_q <= 1'b1;
								idx_q <= count_q;
							end
						end
					end else begin
						rate_q <= val_rd_s1;
						t2_q   <= key_rd_s1;
					end
				end else begin
					// hold the last value read for top extrapolation
					if (func_q == plcl_pkg::FUNC_LOOKUP) rate_q <= val_rd_s1;
					idx_q <= idx_q + CB'(1);
				end
			end
			plcl_pkg::ST_SHIFT_WR: begin
				idx_q <= idx_q - CB'(1);
			end
			plcl_pkg::ST_PAIR_WAIT: begin
				t1_q   <= key_rd_s1;
				r1_q   <= val_rd_s1;
				neg_q  <= diff[RB];
				mag_q  <= diff[RB] ? -diff : diff;
				span_q <= t2_q - key_rd_s1;
			end
			plcl_pkg::ST_ADD: begin
				rate_q <= neg_q ? r1_q - div_quo[RB-1:0] : r1_q + div_quo[RB-1:0];
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rate_out  = $signed(rate_q);
	assign status    = status_q;
endmodule

// ===== bench/piecewise_linear_curve_lookup_core_tb.sv =====
// Testbench for piecewise_linear_curve_lookup_core: directed and random insert/lookup requests.
// Predicts each result with a local sorted-curve model and checks rate_out and status in order.
// Depends on plcl_pkg and the core RTL.
`timescale 1ns / 100ps

module piecewise_linear_curve_lookup_core_tb;
	localparam int NPTS = plcl_pkg::MAX_POINTS_DEF;

	typedef struct {
		logic              fn;
		logic [15:0]       key;
		logic signed [31:0] pct;
	} request_t;

	typedef struct {
		logic signed [39:0] rate;
		logic [1:0]         stat;
	} curve_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic func = 1'b0;
	logic [15:0] key_day = '0;
	logic signed [31:0] pct_value = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic signed [39:0] rate_out;
	logic [1:0] status;

	request_t pending_requests[$];
	curve_result_t expected_results[$];
	logic [15:0] curve_keys[NPTS];
	logic signed [39:0] curve_rates[NPTS];
	int curve_len = 0;
	int mismatches = 0;
	int req_gap = 0;
	int rsp_gap = 0;

	piecewise_linear_curve_lookup_core dut (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
		.func(func), .key_day(key_day), .pct_value(pct_value), .rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall), .rate_out(rate_out), .status(status)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic signed [39:0] percent_to_fraction(logic signed [31:0] pct);
		longint scaled;
		longint mag;
		scaled = longint'(pct) * 256;
		mag = (scaled < 0) ? -scaled : scaled;
		mag = (mag + 50) / 100;
		return (scaled < 0) ? 40'(-mag) : 40'(mag);
	endfunction

	function automatic curve_result_t evaluate_curve(request_t r);
		curve_result_t res;
		int i;
		longint d;
		longint mag;
		longint span;
		longint q;
		res.rate = '0;
		res.stat = plcl_pkg::STAT_OK;
		i = 0;
		while (i < curve_len && curve_keys[i] < r.key)
			i++;
		if (r.fn == plcl_pkg::FUNC_INSERT) begin
			if (i < curve_len && curve_keys[i] == r.key) begin
				curve_rates[i] = percent_to_fraction(r.pct);
			end else if (curve_len >= NPTS) begin
				res.stat = plcl_pkg::STAT_FULL;
			end else begin
				for (int j = curve_len; j > i; j--) begin
					curve_keys[j] = curve_keys[j-1];
					curve_rates[j] = curve_rates[j-1];
				end
				curve_keys[i] = r.key;
				curve_rates[i] = percent_to_fraction(r.pct);
				curve_len++;
			end
		end else if (curve_len == 0) begin
			res.stat = plcl_pkg::STAT_EMPTY;
		end else if (i == 0) begin
			res.rate = curve_rates[0];
		end else if (i >= curve_len) begin
			res.rate = curve_rates[curve_len-1];
		end else begin
			d = longint'(curve_rates[i]) - longint'(curve_rates[i-1]);
			mag = (d < 0) ? -d : d;
			span = longint'(curve_keys[i]) - longint'(curve_keys[i-1]);
			q = longint'(r.key - curve_keys[i-1]) * (mag / span)
				+ (longint'(r.key - curve_keys[i-1]) * (mag % span)) / span;
			res.rate = (d < 0) ? 40'(longint'(curve_rates[i-1]) - q)
				: 40'(longint'(curve_rates[i-1]) + q);
		end
		return res;
	endfunction

	function automatic int random_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic queue_request(logic fn, logic [15:0] key, logic signed [31:0] pct);
		request_t r;
		r.fn = fn;
		r.key = key;
		r.pct = pct;
		pending_requests.push_back(r);
	endtask

	function automatic logic signed [31:0] random_pct();
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return $signed($urandom_range(0, 2000 << 16)) - (1000 <<< 16);
	endfunction

	always @(posedge clk) begin
		if (req_valid && !req_stall) begin
			expected_results.push_back(evaluate_curve('{func, key_day, pct_value}));
		end
		if (!req_valid || !req_stall) begin
			if (req_gap > 0) begin
				req_gap <= req_gap - 1;
				req_valid <= 1'b0;
			end else if (arst_n && pending_requests.size() > 0) begin
				request_t r;
				r = pending_requests.pop_front();
				req_valid <= 1'b1;
				func <= r.fn;
				key_day <= r.key;
				pct_value <= r.pct;
				req_gap <= random_gap();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall) begin
			curve_result_t e;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result rate=%0d status=%0d", rate_out, status);
			end else begin
				e = expected_results.pop_front();
				if (rate_out !== e.rate || status !== e.stat) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected rate=%0d status=%0d, got rate=%0d status=%0d",
							e.rate, e.stat, rate_out, status);
				end
			end
		end
		if (rsp_gap > 0) begin
			rsp_gap <= rsp_gap - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
			rsp_gap <= random_gap();
		end
	end

	initial begin
		logic [15:0] base_keys[$];
		logic [15:0] k;
		queue_request(plcl_pkg::FUNC_LOOKUP, 16'd100, 32'sd0);
		queue_request(plcl_pkg::FUNC_INSERT, 16'd1000, 32'sd5 <<< 16);
		queue_request(plcl_pkg::FUNC_LOOKUP, 16'd0, 32'sd0);
		queue_request(plcl_pkg::FUNC_LOOKUP, 16'hFFFF, 32'sd0);
		queue_request(plcl_pkg::FUNC_INSERT, 16'd0, 32'h7FFF_FFFF);
		queue_request(plcl_pkg::FUNC_INSERT, 16'hFFFF, 32'h8000_0000);
		queue_request(plcl_pkg::FUNC_LOOKUP, 16'd0, 32'sd0);
		queue_request(plcl_pkg::FUNC_LOOKUP, 16'hFFFF, 32'sd0);
		queue_request(plcl_pkg::FUNC_LOOKUP, 16'd1000, 32'sd0);
		queue_request(plcl_pkg::FUNC_LOOKUP, 16'd500, 32'sd0);
		queue_request(plcl_pkg::FUNC_LOOKUP, 16'd40000, 32'sd0);
		queue_request(plcl_pkg::FUNC_INSERT, 16'd1000, -32'sd3);
		queue_request(plcl_pkg::FUNC_LOOKUP, 16'd999, 32'sd0);
		queue_request(plcl_pkg::FUNC_INSERT, 16'd1001, 32'sd50);
		queue_request(plcl_pkg::FUNC_LOOKUP, 16'd1001, 32'hFFFF_FFFF);
		for (int n = 0; n < 280; n++) begin
			int phase;
			phase = n / 70;
			if (phase == 1 || phase == 3) begin
				if ($urandom_range(0, 1) == 0)
					queue_request(plcl_pkg::FUNC_INSERT, 16'($urandom), random_pct());
				else
					queue_request(plcl_pkg::FUNC_LOOKUP, 16'($urandom), $urandom);
			end else if ($urandom_range(0, 2) == 0) begin
				k = (base_keys.size() > 0 && $urandom_range(0, 2) == 0)
					? base_keys[$urandom_range(0, base_keys.size() - 1)] : 16'($urandom);
				base_keys.push_back(k);
				queue_request(plcl_pkg::FUNC_INSERT, k, random_pct());
			end else begin
				queue_request(plcl_pkg::FUNC_LOOKUP, 16'($urandom), 32'sd0);
			end
		end
		for (int n = 0; n < 40; n++)
			queue_request(plcl_pkg::FUNC_INSERT, 16'($urandom_range(0, 255) * 256),
				random_pct());
		for (int n = 0; n < 120; n++) begin
			if ($urandom_range(0, 3) == 0)
				queue_request(plcl_pkg::FUNC_INSERT, 16'($urandom), random_pct());
			else
				queue_request(plcl_pkg::FUNC_LOOKUP, 16'($urandom), 32'sd0);
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_requests.size() == 0 && !req_valid);
		wait (expected_results.size() == 0);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("piecewise_linear_curve_lookup_core_tb OK");
		else
			$display("piecewise_linear_curve_lookup_core_tb NOT OK");
		$finish;
	end

	initial begin
		#20ms;
		$display("piecewise_linear_curve_lookup_core_tb NOT OK");
		$finish;
	end
endmodule
